// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int unsigned FieldWidth = 32;
    localparam int unsigned CapWidth   = 5;
    localparam logic [CapWidth-1:0] CapReset = 5'd16;

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_SET = 1'b1
    } t_req;

    // front to back queue entry
    typedef struct packed {
        t_req                  req;
        logic [FieldWidth-1:0] key;
        logic [FieldWidth-1:0] value;
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage

// ===== rtl/lkvc_if.sv =====
// ----------------------------------------------------------------------------
// lkvc_req_if / lkvc_rsp_if / lkvc_cfg_if
// Valid/ready channels of the cache.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  req_type;
    logic [31:0] lookup_key;
    logic [31:0] write_value;
    modport source (output valid, req_type, lookup_key, write_value, input ready);
    modport sink   (input valid, req_type, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] read_value;
    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lkvc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/lkvc_front.sv =====
// ----------------------------------------------------------------------------
// lkvc_front
// Accepts requests and classifies them into a two-entry command queue.
// ----------------------------------------------------------------------------
module lkvc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lkvc_req_if.sink        req,
    output lkvc_pkg::t_cmd  o_cmd,
    output logic            o_cmd_valid,
    input  logic            i_cmd_pop
);
    import lkvc_pkg::*;

    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push;

    assign req.ready   = (r_cnt != 2'd2);
    assign push        = req.valid && req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
            if (i_cmd_pop) r_rd <= ~r_rd;
        end
        if (push) begin
            r_q[r_rd ^ r_cnt[0]] <= '{req: t_req'(req.req_type), key: req.lookup_key,
                                     value: req.write_value};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(r_cnt == 2'd3))
        else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !i_cmd_pop)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_cmd_pop) |=> (r_cnt == 2'd2))
        else $error("full queue lost an entry");
endmodule

// ===== rtl/lkvc_back.sv =====
// ----------------------------------------------------------------------------
// lkvc_back
// Entry table: parallel key match, recency ranks, fill and eviction.
// ----------------------------------------------------------------------------
module lkvc_back #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lkvc_pkg::t_cmd             i_cmd,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_pop,
    input  logic [lkvc_pkg::CapWidth-1:0] i_capacity,
    lkvc_rsp_if.source                 rsp
);
    import lkvc_pkg::*;

    localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CapW = (CntW > CapWidth) ? CntW : CapWidth;

    logic [DATA_WIDTH-1:0] r_keys [MAX_ENTRIES];
    logic [DATA_WIDTH-1:0] r_vals [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [IdxW-1:0]       r_rank [MAX_ENTRIES];
    logic [CntW-1:0]       r_occ;
    logic                  r_rsp_valid;
    logic                  r_hit;
    logic [FieldWidth-1:0] r_rdata;

    logic [DATA_WIDTH-1:0] key, val;
    logic [MAX_ENTRIES-1:0] match;
    logic                  found, full, have_free;
    logic [IdxW-1:0]       hit_idx, free_idx, lru_idx, slot;
    logic [CapW-1:0]       eff_cap;
    logic [IdxW-1:0]       ref_rank;
    logic                  is_touch;
    logic [DATA_WIDTH-1:0] hit_val;

    assign key = DATA_WIDTH'($signed(i_cmd.key));
    assign val = DATA_WIDTH'($signed(i_cmd.value));

    always_comb begin
        eff_cap = CapW'(i_capacity);
        if (eff_cap == '0) eff_cap = CapW'(1);
        if (eff_cap > CapW'(MAX_ENTRIES)) eff_cap = CapW'(MAX_ENTRIES);
        match = '0; found = 1'b0; hit_idx = '0;
        have_free = 1'b0; free_idx = '0; lru_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_keys[i] == key);
            if (match[i] && !found) begin
                found = 1'b1; hit_idx = IdxW'(i);
            end
            if (!r_valid[i] && !have_free) begin
                have_free = 1'b1; free_idx = IdxW'(i);
            end
        end
        // least recent valid: rank occ-1, ranks unique among valid entries
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (r_valid[i] && r_rank[i] == IdxW'(r_occ - CntW'(1))) lru_idx = IdxW'(i);
        end
        full     = (CapW'(r_occ) >= eff_cap) || !have_free;
        is_touch = found || full;
        slot     = found ? hit_idx : (full ? lru_idx : free_idx);
        ref_rank = r_rank[slot];
        hit_val  = r_vals[hit_idx];
    end

    assign o_cmd_pop = i_cmd_valid && (!r_rsp_valid || rsp.ready);
    assign rsp.valid      = r_rsp_valid;
    assign rsp.hit        = r_hit;
    assign rsp.read_value = r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_occ       <= '0;
            r_rsp_valid <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) r_rank[i] <= '0;
        end else begin
            if (rsp.ready) r_rsp_valid <= 1'b0;
            if (o_cmd_pop) begin
                if (i_cmd.req == REQ_GET) begin
                    r_rsp_valid <= 1'b1;
                    r_hit       <= found;
                    r_rdata     <= found ? FieldWidth'(hit_val) : '1;
                end
                if (found || i_cmd.req == REQ_SET) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (r_valid[i] && IdxW'(i) != slot &&
                            (!is_touch || r_rank[i] < ref_rank))
                            r_rank[i] <= r_rank[i] + IdxW'(1);
                    end
                    r_rank[slot] <= '0;
                end
                if (i_cmd.req == REQ_SET && !found && !full) begin
                    r_valid[free_idx] <= 1'b1;
                    r_occ <= r_occ + CntW'(1);
                end
            end
        end
        if (o_cmd_pop && i_cmd.req == REQ_SET) begin
            r_vals[slot] <= val;
            if (!found) r_keys[slot] <= key;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy mismatch");
    // queue slots hold no command until first written, so check only live keys
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> $onehot0(match))
        else $error("duplicate key");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !rsp.ready) |=> (r_rsp_valid && $stable(r_rdata)))
        else $error("stalled result changed");
endmodule

// ===== rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with LRU replacement.
// ----------------------------------------------------------------------------
// Channels: req (get/set requests), rsp (one result per get), cfg (capacity).
// A request transfer enters a two-entry command queue; the back end executes
// one command per cycle unless a result waits on rsp, with a combinational
// parallel key match and rank update over all entries. A get passes through a
// queue entry and then the result register before reaching rsp. Sustained
// throughput is one request per cycle while rsp is taken; a stalled result
// register holds and the queue then fills, so req ready drops. Sets produce no
// result. Reset (synchronous, active low) clears all valid bits, ranks,
// occupancy, and sets capacity to 16; keys and values need no clearing. Users must
// write capacity on cfg only while idle; the block does not enforce it. Zero behaves as one.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lkvc_req_if.sink   req,
    lkvc_rsp_if.source rsp,
    lkvc_cfg_if.sink   cfg
);
    import lkvc_pkg::*;

    t_cmd                cmd;
    logic                cmd_valid, cmd_pop;
    logic [CapWidth-1:0] r_cap;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= CapReset;
        else if (cfg.valid) r_cap <= cfg.data;
    end

    lkvc_front u_front (
        .i_clk, .i_rst_n, .req,
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop)
    );

    lkvc_back #(.MAX_ENTRIES(MAX_ENTRIES), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd(cmd), .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop),
        .i_capacity(r_cap), .rsp
    );
endmodule
